// ===== src/pidc_pkg.sv =====
package pidc_pkg;

   // Data formats: signed fixed point with FRAC_W fraction bits.
   localparam int DATA_W = 32;
   localparam int FRAC_W = 16;
   localparam int ACC_W  = 48;

   // Derived widths.
   localparam int RATE_W = DATA_W - 1;          // unsigned dt and 1/dt
   localparam int ERR_W  = DATA_W + 1;          // target - measured
   localparam int A_W    = DATA_W + 2;          // widest short operand (error difference)
   localparam int B_LO_W = ACC_W / 2;           // low slice of the long operand
   localparam int B_HI_W = ACC_W - B_LO_W;      // high slice of the long operand
   localparam int MB_W   = B_LO_W + 1;          // multiplier port for either slice
   localparam int PP_W   = A_W + MB_W;          // partial product
   localparam int PROD_W = A_W + ACC_W;         // full product
   localparam int SHR_W  = PROD_W - FRAC_W;     // product after the fraction shift

   // Stream payload widths, padded to whole bytes.
   localparam int REQ_W = ((2 * DATA_W + 7) / 8) * 8;
   localparam int RSP_W = ((DATA_W + 7) / 8) * 8;

   // Register file.
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PROP_GAIN  = 3'd0,
      REG_INTEG_GAIN = 3'd1,
      REG_DERIV_GAIN = 3'd2,
      REG_STEP_TIME  = 3'd3,
      REG_STEP_RATE  = 3'd4,
      REG_DRIVE_MAX  = 3'd5,
      REG_DRIVE_MIN  = 3'd6
   } csr_reg_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] prop_gain;
      logic signed [DATA_W-1:0] integ_gain;
      logic signed [DATA_W-1:0] deriv_gain;
      logic [RATE_W-1:0]        step_time;
      logic [RATE_W-1:0]        step_rate;
      logic signed [DATA_W-1:0] drive_max;
      logic signed [DATA_W-1:0] drive_min;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      prop_gain:  DATA_W'(98304),
      integ_gain: DATA_W'(29491),
      deriv_gain: DATA_W'(83886),
      step_time:  RATE_W'(6554),
      step_rate:  RATE_W'(655360),
      drive_max:  DATA_W'(6553600),
      drive_min:  DATA_W'(-6553600)
   };

   // Saturation limits of the accumulator format.
   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   // Microcode fields.
   typedef enum logic [2:0] {
      A_NONE, A_ERR, A_DIFF, A_KP, A_KI, A_KD
   } a_sel_type;

   typedef enum logic [2:0] {
      B_NONE, B_DT, B_RATE, B_ERR, B_INTEG, B_DERIV
   } b_sel_type;

   typedef enum logic [1:0] {
      MUL_NONE, MUL_LO, MUL_HI
   } mul_op_type;

   typedef enum logic [2:0] {
      WB_NONE, WB_INTEG, WB_DERIV, WB_SUM_SET, WB_SUM_ADD
   } wb_op_type;

   typedef enum logic [1:0] {
      STALL_NONE, STALL_NO_REQ, STALL_OUT_FULL
   } stall_type;

   localparam int STEPS = 16;
   localparam int PC_W  = $clog2(STEPS);

   typedef struct packed {
      a_sel_type        a_sel;    // short multiplier operand
      b_sel_type        b_sel;    // long multiplier operand
      mul_op_type       mul;      // which slice of the long operand to multiply
      logic             fin;      // combine the two partial products, shift, saturate
      wb_op_type        wb;       // where the finished product goes
      logic             load;     // take an input beat
      logic             emit;     // clamp and hand the result to the output register
      stall_type        stall;    // hold this step while the condition is true
      logic [PC_W-1:0]  next_pc;  // step that follows when not held
   } uword_type;

   localparam logic [PC_W-1:0] STEP_IDLE = PC_W'(0);
   localparam logic [PC_W-1:0] STEP_EMIT = PC_W'(13);

   // The program. Each product takes a low pass and a high pass on the shared
   // multiplier, is finished one step later and written back the step after.
   // Products overlap so the multiplier is busy in every step from 1 to 10.
   localparam uword_type UCODE [STEPS] = '{
      // idle: wait for a request, latch error and error difference
      '{A_NONE, B_NONE,  MUL_NONE, 1'b0, WB_NONE,    1'b1, 1'b0, STALL_NO_REQ,   PC_W'(1)},
      // error * dt
      '{A_ERR,  B_DT,    MUL_LO,   1'b0, WB_NONE,    1'b0, 1'b0, STALL_NONE,     PC_W'(2)},
      '{A_ERR,  B_DT,    MUL_HI,   1'b0, WB_NONE,    1'b0, 1'b0, STALL_NONE,     PC_W'(3)},
      // error difference * 1/dt
      '{A_DIFF, B_RATE,  MUL_LO,   1'b1, WB_NONE,    1'b0, 1'b0, STALL_NONE,     PC_W'(4)},
      '{A_DIFF, B_RATE,  MUL_HI,   1'b0, WB_INTEG,   1'b0, 1'b0, STALL_NONE,     PC_W'(5)},
      // Kp * error
      '{A_KP,   B_ERR,   MUL_LO,   1'b1, WB_NONE,    1'b0, 1'b0, STALL_NONE,     PC_W'(6)},
      '{A_KP,   B_ERR,   MUL_HI,   1'b0, WB_DERIV,   1'b0, 1'b0, STALL_NONE,     PC_W'(7)},
      // Ki * integral
      '{A_KI,   B_INTEG, MUL_LO,   1'b1, WB_NONE,    1'b0, 1'b0, STALL_NONE,     PC_W'(8)},
      '{A_KI,   B_INTEG, MUL_HI,   1'b0, WB_SUM_SET, 1'b0, 1'b0, STALL_NONE,     PC_W'(9)},
      // Kd * derivative
      '{A_KD,   B_DERIV, MUL_LO,   1'b1, WB_NONE,    1'b0, 1'b0, STALL_NONE,     PC_W'(10)},
      '{A_KD,   B_DERIV, MUL_HI,   1'b0, WB_SUM_ADD, 1'b0, 1'b0, STALL_NONE,     PC_W'(11)},
      // drain the pipeline
      '{A_NONE, B_NONE,  MUL_NONE, 1'b1, WB_NONE,    1'b0, 1'b0, STALL_NONE,     PC_W'(12)},
      '{A_NONE, B_NONE,  MUL_NONE, 1'b0, WB_SUM_ADD, 1'b0, 1'b0, STALL_NONE,     PC_W'(13)},
      // clamp and emit once the output register can take the beat
      '{A_NONE, B_NONE,  MUL_NONE, 1'b0, WB_NONE,    1'b0, 1'b1, STALL_OUT_FULL, STEP_IDLE},
      // unused steps return to idle
      '{A_NONE, B_NONE,  MUL_NONE, 1'b0, WB_NONE,    1'b0, 1'b0, STALL_NONE,     STEP_IDLE},
      '{A_NONE, B_NONE,  MUL_NONE, 1'b0, WB_NONE,    1'b0, 1'b0, STALL_NONE,     STEP_IDLE}
   };

   // Saturate a shifted product to the accumulator range.
   function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SHR_W-1:0] v);
      logic signed [SHR_W-1:0] hi_lim;
      logic signed [SHR_W-1:0] lo_lim;
      hi_lim = SHR_W'(ACC_MAX);
      lo_lim = SHR_W'(ACC_MIN);
      if (v > hi_lim) begin
         return ACC_MAX;
      end else if (v < lo_lim) begin
         return ACC_MIN;
      end
      return v[ACC_W-1:0];
   endfunction

   // Saturating add in the accumulator format.
   function automatic logic signed [ACC_W-1:0] add_sat(input logic signed [ACC_W-1:0] a,
                                                      input logic signed [ACC_W-1:0] b);
      logic signed [ACC_W:0] s;
      s = (ACC_W+1)'(a) + (ACC_W+1)'(b);
      if (s[ACC_W] != s[ACC_W-1]) begin
         return s[ACC_W] ? ACC_MIN : ACC_MAX;
      end
      return s[ACC_W-1:0];
   endfunction

endpackage

// ===== src/pidc_sequencer.sv =====
module pidc_sequencer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 out_full,
   output logic                 req_ready,
   output pidc_pkg::uword_type  ctrl
);

   logic [pidc_pkg::PC_W-1:0] pc_ff;
   logic [pidc_pkg::PC_W-1:0] pc_in;
   pidc_pkg::uword_type       word;
   logic                      hold;

   // Fetch the control word of the current step.
   assign word = pidc_pkg::UCODE[pc_ff];

   // Evaluate the wait condition of this step.
   always_comb begin
      case (word.stall)
         pidc_pkg::STALL_NONE:     hold = 1'b0;
         pidc_pkg::STALL_NO_REQ:   hold = !req_valid;
         pidc_pkg::STALL_OUT_FULL: hold = out_full;
         default:                  hold = 1'b0;
      endcase
   end

   // A held step does nothing but wait.
   always_comb begin
      ctrl = word;
      if (hold) begin
         ctrl.load = 1'b0;
         ctrl.emit = 1'b0;
      end
      pc_in = hold ? pc_ff : word.next_pc;
   end

   assign req_ready = word.load;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= pidc_pkg::STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   // An accepted beat always reaches the emit step, as no step on the way can be held.
   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> ##(pidc_pkg::STEP_EMIT) (pc_ff == pidc_pkg::STEP_EMIT))
      else $error("emit step not reached on schedule");

   // The unused tail of the program is never entered.
   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      pc_ff <= pidc_pkg::STEP_EMIT)
      else $error("step counter out of program");

endmodule

// ===== src/pidc_datapath.sv =====
module pidc_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  pidc_pkg::uword_type                ctrl,
   input  pidc_pkg::cfg_type                  cfg,
   input  logic signed [pidc_pkg::DATA_W-1:0] target,
   input  logic signed [pidc_pkg::DATA_W-1:0] measured,
   output logic [pidc_pkg::DATA_W-1:0]        drive,
   output logic                               clamped
);

   // Controller state.
   logic signed [pidc_pkg::ERR_W-1:0]  last_ff, last_in;
   logic signed [pidc_pkg::ACC_W-1:0]  integ_ff, integ_in;

   // Per-item working registers.
   logic signed [pidc_pkg::ERR_W-1:0]  err_ff, err_in;
   logic signed [pidc_pkg::A_W-1:0]    diff_ff, diff_in;
   logic signed [pidc_pkg::ACC_W-1:0]  deriv_ff, deriv_in;
   logic signed [pidc_pkg::ACC_W-1:0]  sum_ff, sum_in;

   // Multiplier pipeline.
   logic signed [pidc_pkg::PP_W-1:0]   pp_ff, pp_in;
   logic signed [pidc_pkg::PP_W-1:0]   lo_ff, lo_in;
   logic signed [pidc_pkg::ACC_W-1:0]  prod_ff, prod_in;

   logic signed [pidc_pkg::A_W-1:0]    a_op;
   logic signed [pidc_pkg::ACC_W-1:0]  b_op;
   logic signed [pidc_pkg::B_HI_W-1:0] b_hi;
   logic signed [pidc_pkg::MB_W-1:0]   b_part;
   logic signed [pidc_pkg::PROD_W-1:0] full;
   logic signed [pidc_pkg::SHR_W-1:0]  shifted;
   logic signed [pidc_pkg::ERR_W-1:0]  err_new;
   logic signed [pidc_pkg::ACC_W-1:0]  max_ext, min_ext;

   // Short operand select.
   always_comb begin
      case (ctrl.a_sel)
         pidc_pkg::A_ERR:  a_op = pidc_pkg::A_W'(err_ff);
         pidc_pkg::A_DIFF: a_op = diff_ff;
         pidc_pkg::A_KP:   a_op = pidc_pkg::A_W'(cfg.prop_gain);
         pidc_pkg::A_KI:   a_op = pidc_pkg::A_W'(cfg.integ_gain);
         pidc_pkg::A_KD:   a_op = pidc_pkg::A_W'(cfg.deriv_gain);
         default:          a_op = '0;
      endcase
   end

   // Long operand select; dt and 1/dt are unsigned and zero-extended.
   always_comb begin
      case (ctrl.b_sel)
         pidc_pkg::B_DT:    b_op = pidc_pkg::ACC_W'(cfg.step_time);
         pidc_pkg::B_RATE:  b_op = pidc_pkg::ACC_W'(cfg.step_rate);
         pidc_pkg::B_ERR:   b_op = pidc_pkg::ACC_W'(err_ff);
         pidc_pkg::B_INTEG: b_op = integ_ff;
         pidc_pkg::B_DERIV: b_op = deriv_ff;
         default:           b_op = '0;
      endcase
   end

   // The low slice is taken as unsigned, the high slice keeps the sign.
   assign b_hi = b_op[pidc_pkg::ACC_W-1:pidc_pkg::B_LO_W];

   always_comb begin
      if (ctrl.mul == pidc_pkg::MUL_LO) begin
         b_part = $signed({1'b0, b_op[pidc_pkg::B_LO_W-1:0]});
      end else begin
         b_part = pidc_pkg::MB_W'(b_hi);
      end
   end

   // Shared multiplier: one slice per cycle, low product kept for the finish step.
   always_comb begin
      pp_in = pp_ff;
      lo_in = lo_ff;
      if (ctrl.mul != pidc_pkg::MUL_NONE) begin
         pp_in = a_op * b_part;
      end
      if (ctrl.mul == pidc_pkg::MUL_HI) begin
         lo_in = pp_ff;
      end
   end

   // Finish: recombine, floor-shift by the fraction width, saturate.
   assign full    = (pidc_pkg::PROD_W'(pp_ff) <<< pidc_pkg::B_LO_W) + pidc_pkg::PROD_W'(lo_ff);
   assign shifted = pidc_pkg::SHR_W'(full >>> pidc_pkg::FRAC_W);
   assign prod_in = ctrl.fin ? pidc_pkg::sat_acc(shifted) : prod_ff;

   // Input beat: form the error and its change; the error becomes the stored one.
   assign err_new = pidc_pkg::ERR_W'(target) - pidc_pkg::ERR_W'(measured);

   always_comb begin
      err_in  = err_ff;
      diff_in = diff_ff;
      last_in = last_ff;
      if (ctrl.load) begin
         err_in  = err_new;
         diff_in = pidc_pkg::A_W'(err_new) - pidc_pkg::A_W'(last_ff);
         last_in = err_new;
      end
   end

   // Write-back of finished products.
   always_comb begin
      integ_in = integ_ff;
      deriv_in = deriv_ff;
      sum_in   = sum_ff;
      case (ctrl.wb)
         pidc_pkg::WB_INTEG:   integ_in = pidc_pkg::add_sat(integ_ff, prod_ff);
         pidc_pkg::WB_DERIV:   deriv_in = prod_ff;
         pidc_pkg::WB_SUM_SET: sum_in   = prod_ff;
         pidc_pkg::WB_SUM_ADD: sum_in   = pidc_pkg::add_sat(sum_ff, prod_ff);
         default:              ;
      endcase
   end

   // Output clamp; the upper limit is tested first.
   assign max_ext = pidc_pkg::ACC_W'(cfg.drive_max);
   assign min_ext = pidc_pkg::ACC_W'(cfg.drive_min);

   always_comb begin
      if (sum_ff > max_ext) begin
         drive   = cfg.drive_max;
         clamped = 1'b1;
      end else if (sum_ff < min_ext) begin
         drive   = cfg.drive_min;
         clamped = 1'b1;
      end else begin
         drive   = sum_ff[pidc_pkg::DATA_W-1:0];
         clamped = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff  <= '0;
         integ_ff <= '0;
      end else begin
         last_ff  <= last_in;
         integ_ff <= integ_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff   <= err_in;
      diff_ff  <= diff_in;
      deriv_ff <= deriv_in;
      sum_ff   <= sum_in;
      pp_ff    <= pp_in;
      lo_ff    <= lo_in;
      prod_ff  <= prod_in;
   end

endmodule

// ===== src/pid_controller_clamped_unit.sv =====
// Clamped PID regulator in signed Q16.16. Each request beat carries a setpoint and a
// measurement; the unit returns one response beat with the drive value limited to the
// configured range and a flag that is set when the limit was applied. Integral and
// intermediate terms saturate at 48 bits. A request is taken only in the idle step, so
// the next one waits until the previous item has run through the program: a 14-step
// microprogram runs all five products through one shared 34 x 25 bit multiplier, two
// passes per product. The response sits in an output register, so the next request is
// taken while it waits; only when a response is still held at the emit step of the next
// item does the program stop there until the held beat is taken.
// The user writes gains, dt, 1/dt and limits via the csr port between items, unenforced.
module pid_controller_clamped_unit (
   input  logic                               clock,
   input  logic                               reset,
   // Request stream.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [pidc_pkg::REQ_W-1:0]         req_tdata,   // target, measured
   // Response stream.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [pidc_pkg::RSP_W-1:0]         rsp_tdata,   // drive
   output logic                               rsp_tuser,   // clamped
   // Register writes.
   input  logic                               csr_we,
   input  logic [pidc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pidc_pkg::DATA_W-1:0]        csr_wdata
);

   pidc_pkg::cfg_type              cfg_ff, cfg_in;
   pidc_pkg::uword_type            ctrl;
   logic                           out_full;
   logic [pidc_pkg::DATA_W-1:0]    drive;
   logic                           clamped;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [pidc_pkg::DATA_W-1:0]    rsp_drive_ff, rsp_drive_in;
   logic                           rsp_clamped_ff, rsp_clamped_in;

   // Register file writes; an index beyond the list is ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (pidc_pkg::csr_reg_type'(csr_index))
            pidc_pkg::REG_PROP_GAIN:  cfg_in.prop_gain  = csr_wdata;
            pidc_pkg::REG_INTEG_GAIN: cfg_in.integ_gain = csr_wdata;
            pidc_pkg::REG_DERIV_GAIN: cfg_in.deriv_gain = csr_wdata;
            pidc_pkg::REG_STEP_TIME:  cfg_in.step_time  = csr_wdata[pidc_pkg::RATE_W-1:0];
            pidc_pkg::REG_STEP_RATE:  cfg_in.step_rate  = csr_wdata[pidc_pkg::RATE_W-1:0];
            pidc_pkg::REG_DRIVE_MAX:  cfg_in.drive_max  = csr_wdata;
            pidc_pkg::REG_DRIVE_MIN:  cfg_in.drive_min  = csr_wdata;
            default:                  ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= pidc_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The emit step waits only while a response is held and not being taken.
   assign out_full = rsp_valid_ff && !rsp_tready;

   pidc_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .out_full  (out_full),
      .req_ready (req_tready),
      .ctrl      (ctrl)
   );

   pidc_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .cfg      (cfg_ff),
      .target   (req_tdata[pidc_pkg::DATA_W-1:0]),
      .measured (req_tdata[2*pidc_pkg::DATA_W-1:pidc_pkg::DATA_W]),
      .drive    (drive),
      .clamped  (clamped)
   );

   // Output register.
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_drive_in   = rsp_drive_ff;
      rsp_clamped_in = rsp_clamped_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (ctrl.emit) begin
         rsp_valid_in   = 1'b1;
         rsp_drive_in   = drive;
         rsp_clamped_in = clamped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_drive_ff   <= rsp_drive_in;
      rsp_clamped_ff <= rsp_clamped_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = pidc_pkg::RSP_W'(rsp_drive_ff);
   assign rsp_tuser  = rsp_clamped_ff;

   // A response appears only from the emit step.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctrl.emit))
      else $error("response raised without emit step");

   // The emit step never overwrites a response that has not been taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctrl.emit |-> (!rsp_valid_ff || rsp_tready))
      else $error("pending response overwritten");

endmodule

// ===== tb/pid_controller_clamped_unit_test.sv =====
`timescale 1ns / 1ps

module pid_controller_clamped_unit_test;

   // Index that maps to no register; writes to it must change nothing.
   localparam logic [pidc_pkg::CSR_IDX_W-1:0] CSR_SPARE_INDEX = 3'd7;

   localparam logic signed [pidc_pkg::DATA_W-1:0] DATA_MAX =
      {1'b0, {(pidc_pkg::DATA_W-1){1'b1}}};
   localparam logic signed [pidc_pkg::DATA_W-1:0] DATA_MIN =
      {1'b1, {(pidc_pkg::DATA_W-1){1'b0}}};
   localparam logic [pidc_pkg::RATE_W-1:0]        RATE_MAX = '1;
   localparam logic signed [pidc_pkg::DATA_W-1:0] ONE_Q    =
      pidc_pkg::DATA_W'(1 << pidc_pkg::FRAC_W);

   localparam int SETTINGS_PER_PHASE = 4;
   localparam int ITEMS_PER_SETTING  = 120;
   localparam int DRAIN_CYCLES       = 40;

   typedef enum {
      SET_TYPICAL, SET_EXTREME, SET_WIDE, SET_NARROW
   } setting_kind_type;

   typedef struct packed {
      logic signed [pidc_pkg::DATA_W-1:0] drive;
      logic                               clamped;
   } drive_result_type;

   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [pidc_pkg::REQ_W-1:0]     req_tdata;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [pidc_pkg::RSP_W-1:0]     rsp_tdata;
   logic                           rsp_tuser;
   logic                           csr_we;
   logic [pidc_pkg::CSR_IDX_W-1:0] csr_index;
   logic [pidc_pkg::DATA_W-1:0]    csr_wdata;

   int send_idle_pct = 15;
   int recv_idle_pct = 71;
   int mismatches    = 0;
   int beats_sent    = 0;
   int beats_checked = 0;
   int csr_writes    = 0;

   // Shadow copy of the register file and the regulator state.
   pidc_pkg::cfg_type                 model_cfg;
   logic signed [pidc_pkg::ERR_W-1:0] model_last_error;
   logic signed [pidc_pkg::ACC_W-1:0] model_integral;
   drive_result_type                  expected_drives[$];

   pid_controller_clamped_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // target, measured
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // drive
      .rsp_tuser  (rsp_tuser),   // clamped
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog for a hung handshake or a lost response.
   initial begin
      #2000000;
      $display("FAILURE");
      $finish;
   end

   // Exact product with floor shift, saturated to the accumulator range.
   function automatic logic signed [pidc_pkg::ACC_W-1:0] scaled_product(
      input logic signed [63:0] a,
      input logic signed [63:0] b);
      logic signed [127:0] p;
      logic signed [127:0] hi_lim;
      logic signed [127:0] lo_lim;
      hi_lim = pidc_pkg::ACC_MAX;
      lo_lim = pidc_pkg::ACC_MIN;
      p = a * b;
      p = p >>> pidc_pkg::FRAC_W;
      if (p > hi_lim) return pidc_pkg::ACC_MAX;
      if (p < lo_lim) return pidc_pkg::ACC_MIN;
      return p[pidc_pkg::ACC_W-1:0];
   endfunction

   function automatic logic signed [pidc_pkg::ACC_W-1:0] sum_saturated(
      input logic signed [pidc_pkg::ACC_W-1:0] a,
      input logic signed [pidc_pkg::ACC_W-1:0] b);
      logic signed [pidc_pkg::ACC_W:0] s;
      logic signed [pidc_pkg::ACC_W:0] hi_lim;
      logic signed [pidc_pkg::ACC_W:0] lo_lim;
      hi_lim = pidc_pkg::ACC_MAX;
      lo_lim = pidc_pkg::ACC_MIN;
      s = a + b;
      if (s > hi_lim) return pidc_pkg::ACC_MAX;
      if (s < lo_lim) return pidc_pkg::ACC_MIN;
      return s[pidc_pkg::ACC_W-1:0];
   endfunction

   // One regulator step: updates the shadow state and returns the expected beat.
   function automatic drive_result_type predict_drive(
      input logic signed [pidc_pkg::DATA_W-1:0] tgt,
      input logic signed [pidc_pkg::DATA_W-1:0] meas);
      logic signed [63:0]                 t_ext;
      logic signed [63:0]                 m_ext;
      logic signed [63:0]                 prev;
      logic signed [63:0]                 err;
      logic signed [63:0]                 diff;
      logic signed [63:0]                 dt;
      logic signed [63:0]                 rate;
      logic signed [pidc_pkg::DATA_W-1:0] kp;
      logic signed [pidc_pkg::DATA_W-1:0] ki;
      logic signed [pidc_pkg::DATA_W-1:0] kd;
      logic signed [pidc_pkg::DATA_W-1:0] lim_hi;
      logic signed [pidc_pkg::DATA_W-1:0] lim_lo;
      logic signed [pidc_pkg::ACC_W-1:0]  deriv;
      logic signed [pidc_pkg::ACC_W-1:0]  sum;
      drive_result_type                   r;
      t_ext  = tgt;
      m_ext  = meas;
      prev   = model_last_error;
      dt     = model_cfg.step_time;
      rate   = model_cfg.step_rate;
      kp     = model_cfg.prop_gain;
      ki     = model_cfg.integ_gain;
      kd     = model_cfg.deriv_gain;
      lim_hi = model_cfg.drive_max;
      lim_lo = model_cfg.drive_min;
      err    = t_ext - m_ext;
      diff   = err - prev;

      model_integral = sum_saturated(model_integral, scaled_product(err, dt));
      deriv = scaled_product(diff, rate);
      sum = scaled_product(kp, err);
      sum = sum_saturated(sum, scaled_product(ki, model_integral));
      sum = sum_saturated(sum, scaled_product(kd, deriv));

      // The upper limit is tested first, which matters when the limits cross.
      r.drive   = sum[pidc_pkg::DATA_W-1:0];
      r.clamped = 1'b0;
      if (sum > lim_hi) begin
         r.drive   = lim_hi;
         r.clamped = 1'b1;
      end else if (sum < lim_lo) begin
         r.drive   = lim_lo;
         r.clamped = 1'b1;
      end
      model_last_error = err[pidc_pkg::ERR_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("Mismatch in %s at response beat %0d: got %h, expected %h",
               what, beats_checked, got, want);
      mismatches++;
   endtask

   // Receiver with random back-pressure.
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Compare each response beat with the oldest expectation.
   always @(posedge clock) begin
      drive_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_drives.size() == 0) begin
            report_mismatch("unexpected beat", rsp_tdata, '0);
         end else begin
            want = expected_drives.pop_front();
            if (rsp_tdata[pidc_pkg::DATA_W-1:0] !== want.drive)
               report_mismatch("drive", rsp_tdata, want.drive);
            if (rsp_tuser !== want.clamped)
               report_mismatch("clamped", rsp_tuser, want.clamped);
         end
         beats_checked++;
      end
   end

   // Send one request beat after a random gap and record its expected response.
   task automatic send_sample(input logic signed [pidc_pkg::DATA_W-1:0] tgt,
                              input logic signed [pidc_pkg::DATA_W-1:0] meas);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pidc_pkg::REQ_W'({meas, tgt});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_drives.push_back(predict_drive(tgt, meas));
      beats_sent++;
   endtask

   // Let every outstanding response drain, then give the block time to settle.
   task automatic wait_until_idle();
      req_tvalid <= 1'b0;
      while (expected_drives.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [pidc_pkg::CSR_IDX_W-1:0] idx,
                            input logic [pidc_pkg::DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         pidc_pkg::REG_PROP_GAIN:  model_cfg.prop_gain  = value;
         pidc_pkg::REG_INTEG_GAIN: model_cfg.integ_gain = value;
         pidc_pkg::REG_DERIV_GAIN: model_cfg.deriv_gain = value;
         pidc_pkg::REG_STEP_TIME:  model_cfg.step_time  = value[pidc_pkg::RATE_W-1:0];
         pidc_pkg::REG_STEP_RATE:  model_cfg.step_rate  = value[pidc_pkg::RATE_W-1:0];
         pidc_pkg::REG_DRIVE_MAX:  model_cfg.drive_max  = value;
         pidc_pkg::REG_DRIVE_MIN:  model_cfg.drive_min  = value;
         default: ;
      endcase
      csr_writes++;
   endtask

   function automatic logic signed [pidc_pkg::DATA_W-1:0] rand_small(input int bits);
      int unsigned span;
      span = 1 << bits;
      return $urandom_range(0, 2 * span - 1) - span;
   endfunction

   function automatic logic signed [pidc_pkg::DATA_W-1:0] rand_sample();
      case ($urandom_range(9))
         0:       return DATA_MAX;
         1:       return DATA_MIN;
         2, 3:    return $urandom();
         default: return rand_small(20);
      endcase
   endfunction

   function automatic logic signed [pidc_pkg::DATA_W-1:0] rand_extreme();
      return $urandom_range(1) ? DATA_MAX : DATA_MIN;
   endfunction

   // Program a full register set of the given flavor.
   task automatic apply_setting(input setting_kind_type kind);
      logic signed [pidc_pkg::DATA_W-1:0] lo;
      logic signed [pidc_pkg::DATA_W-1:0] hi;
      logic signed [pidc_pkg::DATA_W-1:0] tmp;
      wait_until_idle();
      case (kind)
         SET_EXTREME: begin
            write_reg(pidc_pkg::REG_PROP_GAIN, rand_extreme());
            write_reg(pidc_pkg::REG_INTEG_GAIN, rand_extreme());
            write_reg(pidc_pkg::REG_DERIV_GAIN, rand_extreme());
            write_reg(pidc_pkg::REG_STEP_TIME, $urandom_range(1) ? RATE_MAX : 1);
            write_reg(pidc_pkg::REG_STEP_RATE, $urandom_range(1) ? RATE_MAX : 1);
            lo = DATA_MIN;
            hi = DATA_MAX;
         end
         SET_WIDE: begin
            write_reg(pidc_pkg::REG_PROP_GAIN, $urandom());
            write_reg(pidc_pkg::REG_INTEG_GAIN, $urandom());
            write_reg(pidc_pkg::REG_DERIV_GAIN, $urandom());
            write_reg(pidc_pkg::REG_STEP_TIME, $urandom());
            write_reg(pidc_pkg::REG_STEP_RATE, $urandom());
            lo = $urandom();
            hi = $urandom();
         end
         default: begin
            write_reg(pidc_pkg::REG_PROP_GAIN, rand_small(18));
            write_reg(pidc_pkg::REG_INTEG_GAIN, rand_small(18));
            write_reg(pidc_pkg::REG_DERIV_GAIN, rand_small(18));
            write_reg(pidc_pkg::REG_STEP_TIME, $urandom_range(1, 1 << 16));
            write_reg(pidc_pkg::REG_STEP_RATE, $urandom_range(1, 1 << 20));
            if (kind == SET_NARROW) begin
               lo = rand_small(16);
               hi = lo + $urandom_range(0, 1 << 16);
            end else begin
               hi = $urandom_range(1, 1 << 28);
               lo = -$urandom_range(1, 1 << 28);
            end
         end
      endcase
      // Now and then the limits are crossed on purpose.
      if ($urandom_range(7) == 0) begin
         tmp = lo;
         lo  = hi;
         hi  = tmp;
      end
      write_reg(pidc_pkg::REG_DRIVE_MAX, hi);
      write_reg(pidc_pkg::REG_DRIVE_MIN, lo);
   endtask

   // Reset register values, with zero, small and extreme errors.
   task automatic test_reset_settings();
      send_sample(0, 0);
      send_sample(ONE_Q, 0);
      send_sample(DATA_MAX, DATA_MIN);
      send_sample(DATA_MIN, DATA_MAX);
      send_sample(DATA_MAX, DATA_MAX);
      send_sample(0, 0);
   endtask

   // Drive the integral register into both saturation limits.
   task automatic test_integral_saturation();
      wait_until_idle();
      write_reg(pidc_pkg::REG_PROP_GAIN, 0);
      write_reg(pidc_pkg::REG_INTEG_GAIN, ONE_Q);
      write_reg(pidc_pkg::REG_DERIV_GAIN, 0);
      write_reg(pidc_pkg::REG_STEP_TIME, RATE_MAX);
      write_reg(pidc_pkg::REG_DRIVE_MAX, DATA_MAX);
      write_reg(pidc_pkg::REG_DRIVE_MIN, DATA_MIN);
      repeat (3) send_sample(DATA_MAX, DATA_MIN);
      repeat (4) send_sample(DATA_MIN, DATA_MAX);
   endtask

   // Extreme gains and rates so the integral and derivative terms and the running sum saturate.
   task automatic test_term_saturation();
      wait_until_idle();
      write_reg(pidc_pkg::REG_PROP_GAIN, DATA_MAX);
      write_reg(pidc_pkg::REG_INTEG_GAIN, DATA_MAX);
      write_reg(pidc_pkg::REG_DERIV_GAIN, DATA_MIN);
      write_reg(pidc_pkg::REG_STEP_RATE, RATE_MAX);
      send_sample(DATA_MAX, DATA_MIN);
      send_sample(DATA_MIN, DATA_MAX);
      send_sample(DATA_MAX, DATA_MIN);
   endtask

   // Lower limit above the upper one.
   task automatic test_inverted_limits();
      wait_until_idle();
      write_reg(pidc_pkg::REG_PROP_GAIN, ONE_Q);
      write_reg(pidc_pkg::REG_INTEG_GAIN, 0);
      write_reg(pidc_pkg::REG_DERIV_GAIN, 0);
      write_reg(pidc_pkg::REG_DRIVE_MAX, -ONE_Q);
      write_reg(pidc_pkg::REG_DRIVE_MIN, ONE_Q);
      send_sample(0, 0);
      send_sample(ONE_Q <<< 4, 0);
      send_sample(0, ONE_Q <<< 4);
   endtask

   // A zero interval freezes the integral and a zero rate removes the derivative term.
   task automatic test_zero_intervals();
      wait_until_idle();
      write_reg(pidc_pkg::REG_INTEG_GAIN, ONE_Q);
      write_reg(pidc_pkg::REG_DERIV_GAIN, ONE_Q);
      write_reg(pidc_pkg::REG_STEP_TIME, 0);
      write_reg(pidc_pkg::REG_STEP_RATE, 0);
      write_reg(pidc_pkg::REG_DRIVE_MAX, DATA_MAX);
      write_reg(pidc_pkg::REG_DRIVE_MIN, DATA_MIN);
      send_sample(ONE_Q, 0);
      send_sample(-ONE_Q, ONE_Q);
      send_sample(DATA_MAX, 0);
   endtask

   // A write to the unused index must leave every register alone.
   task automatic test_spare_index();
      wait_until_idle();
      write_reg(CSR_SPARE_INDEX, $urandom());
      send_sample(ONE_Q, -ONE_Q);
      send_sample(rand_small(20), rand_small(20));
   endtask

   // Control-loop style traffic: the setpoint is held for a while and the measurement
   // stays near it, with occasional jumps and arbitrary values mixed in.
   task automatic test_random_traffic();
      logic signed [pidc_pkg::DATA_W-1:0] target;
      logic signed [pidc_pkg::DATA_W-1:0] measured;
      target = 0;
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 15;
               recv_idle_pct = 71;
            end
            1: begin
               send_idle_pct = 71;
               recv_idle_pct = 15;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int s = 0; s < SETTINGS_PER_PHASE; s++) begin
            apply_setting(setting_kind_type'(s));
            for (int i = 0; i < ITEMS_PER_SETTING; i++) begin
               if ($urandom_range(9) < 2) target = rand_sample();
               if ($urandom_range(9) < 7) measured = target + rand_small(12);
               else measured = rand_sample();
               send_sample(target, measured);
            end
         end
      end
   endtask

   // Test sequence.
   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_index  <= '0;
      csr_wdata  <= '0;
      model_cfg        = pidc_pkg::CFG_RESET;
      model_last_error = '0;
      model_integral   = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_settings();
      test_integral_saturation();
      test_term_saturation();
      test_inverted_limits();
      test_zero_intervals();
      test_spare_index();
      test_random_traffic();
      wait_until_idle();

      $display("Sent %0d request beats, checked %0d response beats, made %0d register writes.",
               beats_sent, beats_checked, csr_writes);
      $display("Covered saturation, crossed limits, zero intervals and three stall patterns.");
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/pidc_pkg.sv
src/pidc_sequencer.sv
src/pidc_datapath.sv
src/pid_controller_clamped_unit.sv
tb/pid_controller_clamped_unit_test.sv
